// ===== src/smps_pkg.sv =====
// Shared types, widths and register codes for the strided modular prefix sum block.
package smps_pkg;

    // Storage and datapath sizes.
    localparam int MAX_COLUMNS = 1024;
    localparam int VALUE_WIDTH = 64;
    localparam int COL_W       = $clog2(MAX_COLUMNS);

    // Register widths.
    localparam int MODULUS_W   = 63;
    localparam int COLS_CFG_W  = 11;
    localparam int ROWS_CFG_W  = 16;
    localparam int CFG_DATA_W  = 63;
    localparam int CFG_INDEX_W = 3;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [VALUE_WIDTH-1:0]        word_t;
    typedef logic [COL_W-1:0]              col_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_INVERSE_MODE = 3'd0,
        REG_MODULAR_MODE = 3'd1,
        REG_MODULUS      = 3'd2,
        REG_COLUMN_COUNT = 3'd3,
        REG_ROW_COUNT    = 3'd4
    } cfg_index_t;

    // Position of one item inside its block.
    typedef struct packed {
        col_t col;
        logic first_row;
    } position_t;

endpackage

// ===== src/smps_store.sv =====
// Column store: one word per column, synchronous read through a data register.
module smps_store (
    input  logic           clk,
    input  logic           rd_en,
    input  smps_pkg::col_t rd_addr,
    output smps_pkg::word_t rd_data,
    input  logic           wr_en,
    input  smps_pkg::col_t wr_addr,
    input  smps_pkg::word_t wr_data
);
    import smps_pkg::*;

    word_t mem [MAX_COLUMNS];
    word_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data register holds while the read is not enabled.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/smps_seq.sv =====
// Row and column position counters that walk the strided coefficient layout.
module smps_seq (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  logic                                 start,
    input  logic [smps_pkg::COLS_CFG_W-1:0]      column_count,
    input  logic [smps_pkg::ROWS_CFG_W-1:0]      row_count,
    output smps_pkg::position_t                  pos
);
    import smps_pkg::*;

    localparam logic [COLS_CFG_W-1:0] COLS_MAX = COLS_CFG_W'(MAX_COLUMNS);

    col_t                  col_pos_reg, col_pos_next;
    logic [ROWS_CFG_W-1:0] row_pos_reg, row_pos_next;
    logic [COLS_CFG_W-1:0] cols;
    logic [ROWS_CFG_W-1:0] rows;
    logic [COLS_CFG_W-1:0] col_cur;
    logic [ROWS_CFG_W-1:0] row_cur;
    logic [COLS_CFG_W-1:0] col_inc;
    logic [ROWS_CFG_W:0]   row_inc;

    // Clamp the counts into their usable ranges.
    always_comb
    begin
        if (column_count == '0)
            cols = COLS_CFG_W'(1);
        else if (column_count > COLS_MAX)
            cols = COLS_MAX;
        else
            cols = column_count;
        rows = (row_count == '0) ? ROWS_CFG_W'(1) : row_count;
    end

    // Position of the current item, with restart and wrap after lowered counts.
    always_comb
    begin
        col_cur = start ? '0 : COLS_CFG_W'(col_pos_reg);
        row_cur = start ? '0 : row_pos_reg;
        if (col_cur >= cols)
            col_cur = '0;
        if (row_cur >= rows)
            row_cur = '0;
        col_inc = col_cur + COLS_CFG_W'(1);
        row_inc = {1'b0, row_cur} + (ROWS_CFG_W+1)'(1);

        if (col_inc >= cols)
        begin
            col_pos_next = '0;
            row_pos_next = (row_inc >= {1'b0, rows}) ? '0 : row_inc[ROWS_CFG_W-1:0];
        end
        else
        begin
            col_pos_next = col_inc[COL_W-1:0];
            row_pos_next = row_cur;
        end

        pos.col       = col_cur[COL_W-1:0];
        pos.first_row = (row_cur == '0);
    end

    // Position registers advance once per accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end
        else if (accept)
        begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
        end
    end

endmodule

// ===== src/smps_alu.sv =====
// Modular or wrapping add and difference with one conditional subtraction of q.
module smps_alu (
    input  smps_pkg::word_t                   x,
    input  smps_pkg::word_t                   prev,
    input  logic                              first_row,
    input  logic                              inverse_mode,
    input  logic                              modular_mode,
    input  logic [smps_pkg::MODULUS_W-1:0]    modulus,
    output smps_pkg::word_t                   y,
    output smps_pkg::word_t                   store
);
    import smps_pkg::*;

    word_t q;
    word_t raw;
    word_t reduced;

    // Raw sum or difference, then one conditional subtraction as a signed compare.
    always_comb
    begin
        q = VALUE_WIDTH'(modulus);
        if (inverse_mode)
            raw = modular_mode ? (x - prev + q) : (x - prev);
        else
            raw = x + prev;
        reduced = ($signed(raw) >= $signed(q)) ? (raw - q) : raw;

        if (first_row)
        begin
            y     = x;
            store = x;
        end
        else
        begin
            y     = modular_mode ? reduced : raw;
            store = inverse_mode ? x : y;
        end
    end

endmodule

// ===== src/strided_modular_prefix_sum.sv =====
// Strided modular prefix sum: the top level with configuration, pipeline and handshakes.
//
// Usage: items (value_in, start_of_tensor) enter on a valid/ready channel in
// memory order, row after row, each row holding column_count interleaved
// columns. start_of_tensor marks row 0, column 0 of a new block. Each item
// gives exactly one result on value_out through a valid/ready output channel.
// Forward mode emits the running sum down each column, inverse mode the
// difference with the previous row's input; the first row passes unchanged.
// An accepted item passes the read stage and then the output register
// before out_valid rises. Throughput is one item per cycle while out_ready
// holds, set by the single read port and single write port of the column
// store; a write of the item ahead is forwarded to a read of the same column.
// When the receiver stalls, one result waits in the output register and one
// more item is still accepted into the read stage; then in_ready drops.
// Reset clears the positions and pipeline and loads the register defaults; the column
// store needs no clearing, since each block's first row writes it. The user must write
// registers through cfg_write, cfg_index and cfg_data only while idle; not enforced.
module strided_modular_prefix_sum (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  smps_pkg::value_t                     value_in,
    input  logic                                 start_of_tensor,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output smps_pkg::value_t                     value_out,
    input  logic                                 cfg_write,
    input  logic [smps_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [smps_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import smps_pkg::*;

    logic                  inverse_mode_reg;
    logic                  modular_mode_reg;
    logic [MODULUS_W-1:0]  modulus_reg;
    logic [COLS_CFG_W-1:0] column_count_reg;
    logic [ROWS_CFG_W-1:0] row_count_reg;

    logic      s1_valid_reg;
    word_t     s1_x_reg;
    col_t      s1_col_reg;
    logic      s1_first_reg;
    logic      fwd_hit_reg;
    word_t     fwd_data_reg;
    logic      out_valid_reg;
    word_t     out_data_reg;

    logic      out_free;
    logic      s1_move;
    logic      accept;
    position_t pos;
    word_t     rd_data;
    word_t     prev;
    word_t     alu_y;
    word_t     alu_store;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inverse_mode_reg <= 1'b0;
            modular_mode_reg <= 1'b1;
            modulus_reg      <= MODULUS_W'(2);
            column_count_reg <= COLS_CFG_W'(1);
            row_count_reg    <= ROWS_CFG_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                REG_INVERSE_MODE: inverse_mode_reg <= cfg_data[0];
                REG_MODULAR_MODE: modular_mode_reg <= cfg_data[0];
                REG_MODULUS:      modulus_reg      <= cfg_data[MODULUS_W-1:0];
                REG_COLUMN_COUNT: column_count_reg <= cfg_data[COLS_CFG_W-1:0];
                REG_ROW_COUNT:    row_count_reg    <= cfg_data[ROWS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the read stage moves when the output register is free.
    assign out_free = !out_valid_reg || out_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign accept   = in_valid && in_ready;

    smps_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .start        (start_of_tensor),
        .column_count (column_count_reg),
        .row_count    (row_count_reg),
        .pos          (pos)
    );

    smps_store u_store (
        .clk     (clk),
        .rd_en   (in_ready),
        .rd_addr (pos.col),
        .rd_data (rd_data),
        .wr_en   (s1_move),
        .wr_addr (s1_col_reg),
        .wr_data (alu_store)
    );

    // Read stage: holds the item while its column word is fetched.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
            fwd_hit_reg  <= s1_move && (s1_col_reg == pos.col);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            s1_x_reg     <= word_t'(value_in);
            s1_col_reg   <= pos.col;
            s1_first_reg <= pos.first_row;
            fwd_data_reg <= alu_store;
        end
    end

    // The item ahead writes the same column at the read edge: take its word.
    assign prev = fwd_hit_reg ? fwd_data_reg : rd_data;

    smps_alu u_alu (
        .x            (s1_x_reg),
        .prev         (prev),
        .first_row    (s1_first_reg),
        .inverse_mode (inverse_mode_reg),
        .modular_mode (modular_mode_reg),
        .modulus      (modulus_reg),
        .y            (alu_y),
        .store        (alu_store)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_data_reg <= alu_y;
        end
    end

    assign out_valid = out_valid_reg;
    assign value_out = value_t'(out_data_reg);

endmodule

// ===== tb/strided_modular_prefix_sum_tb.sv =====
// Self-checking testbench for the strided modular prefix sum block.
`timescale 1ns / 100ps

module strided_modular_prefix_sum_tb;
    import smps_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 550;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned STEP_COUNT   = 40;

    typedef enum logic {STEP_ITEM, STEP_WRITE} step_kind_t;

    // One row of the directed table: either an item or a register write.
    typedef struct packed {
        step_kind_t kind;
        cfg_index_t reg_idx;
        word_t      value;
        logic       sot;
        logic       typed;
        word_t      result;
    } directed_step_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    value_t                 value_in;
    logic                   start_of_tensor;
    logic                   out_valid;
    logic                   out_ready;
    value_t                 value_out;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Shadow copy of the configuration and the column state.
    logic                   cfg_inverse;
    logic                   cfg_modular;
    logic [MODULUS_W-1:0]   cfg_modulus;
    logic [COLS_CFG_W-1:0]  cfg_columns;
    logic [ROWS_CFG_W-1:0]  cfg_rows;
    word_t                  column_words [MAX_COLUMNS];
    bit                     column_written [MAX_COLUMNS];
    int unsigned            column_at;
    int unsigned            row_at;

    word_t                  predicted_values [$];
    int unsigned            accepted_items;
    int unsigned            results_seen;
    int unsigned            failures;
    int unsigned            cycle_count;

    // Directed stimulus; result is typed in only where it is plain to see.
    directed_step_t directed_steps [STEP_COUNT] = '{
        // Reset defaults: one row, so everything passes unchanged.
        '{STEP_ITEM,  REG_INVERSE_MODE, 64'h0, 1'b1, 1'b1, 64'h0},
        '{STEP_ITEM,  REG_INVERSE_MODE, 64'h8000_0000_0000_0000, 1'b0, 1'b1,
          64'h8000_0000_0000_0000},
        '{STEP_ITEM,  REG_INVERSE_MODE, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b1,
          64'h7FFF_FFFF_FFFF_FFFF},
        // A zero row count behaves as one row.
        '{STEP_WRITE, REG_ROW_COUNT,    64'd0, 1'b0, 1'b0, 64'h0},
        '{STEP_ITEM,  REG_INVERSE_MODE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1,
          64'hFFFF_FFFF_FFFF_FFFF},
        // Forward sums modulo 97 over two columns and two rows.
        '{STEP_WRITE, REG_MODULUS,      64'd97, 1'b0, 1'b0, 64'h0},
        '{STEP_WRITE, REG_ROW_COUNT,    64'd2, 1'b0, 1'b0, 64'h0},
        '{STEP_WRITE, REG_COLUMN_COUNT, 64'd2, 1'b0, 1'b0, 64'h0},
        '{STEP_ITEM,  REG_INVERSE_MODE, 64'd90, 1'b1, 1'b1, 64'd90},
        '{STEP_ITEM,  REG_INVERSE_MODE, 64'd5, 1'b0, 1'b1, 64'd5},
        '{STEP_ITEM,  REG_INVERSE_MODE, 64'd20, 1'b0, 1'b0, 64'h0},
        '{STEP_ITEM,  REG_INVERSE_MODE, 64'd96, 1'b0, 1'b0, 64'h0},
        // Modular differences.
        '{STEP_WRITE, REG_INVERSE_MODE, 64'd1, 1'b0, 1'b0, 64'h0},
        '{STEP_ITEM,  REG_INVERSE_MODE, 64'd3, 1'b1, 1'b1, 64'd3},
        '{STEP_ITEM,  REG_INVERSE_MODE, 64'd7, 1'b0, 1'b1, 64'd7},
        '{STEP_ITEM,  REG_INVERSE_MODE, 64'd1, 1'b0, 1'b0, 64'h0},
        // Mode switched back to sums in the middle of a block.
        '{STEP_ITEM,  REG_INVERSE_MODE, 64'd50, 1'b1, 1'b1, 64'd50},
        '{STEP_ITEM,  REG_INVERSE_MODE, 64'd60, 1'b0, 1'b1, 64'd60},
        '{STEP_WRITE, REG_INVERSE_MODE, 64'd0, 1'b0, 1'b0, 64'h0},
        '{STEP_ITEM,  REG_INVERSE_MODE, 64'd50, 1'b0, 1'b0, 64'h0},
        '{STEP_ITEM,  REG_INVERSE_MODE, 64'd40, 1'b0, 1'b0, 64'h0},
        // Plain wrapping differences at the value extremes.
        '{STEP_WRITE, REG_MODULAR_MODE, 64'd0, 1'b0, 1'b0, 64'h0},
        '{STEP_WRITE, REG_MODULUS,      64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0},
        '{STEP_WRITE, REG_INVERSE_MODE, 64'd1, 1'b0, 1'b0, 64'h0},
        '{STEP_ITEM,  REG_INVERSE_MODE, 64'h8000_0000_0000_0000, 1'b1, 1'b1,
          64'h8000_0000_0000_0000},
        '{STEP_ITEM,  REG_INVERSE_MODE, 64'd0, 1'b0, 1'b1, 64'd0},
        '{STEP_ITEM,  REG_INVERSE_MODE, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0},
        '{STEP_ITEM,  REG_INVERSE_MODE, 64'd0, 1'b0, 1'b0, 64'h0},
        // Modulus below two and a zero column count, which acts as one column.
        '{STEP_WRITE, REG_INVERSE_MODE, 64'd0, 1'b0, 1'b0, 64'h0},
        '{STEP_WRITE, REG_MODULAR_MODE, 64'd1, 1'b0, 1'b0, 64'h0},
        '{STEP_WRITE, REG_MODULUS,      64'd0, 1'b0, 1'b0, 64'h0},
        '{STEP_WRITE, REG_COLUMN_COUNT, 64'd0, 1'b0, 1'b0, 64'h0},
        '{STEP_ITEM,  REG_INVERSE_MODE, 64'd5, 1'b1, 1'b1, 64'd5},
        '{STEP_ITEM,  REG_INVERSE_MODE, 64'd7, 1'b0, 1'b0, 64'h0},
        // Column count above the store size, then lowered in the middle of a row.
        '{STEP_WRITE, REG_COLUMN_COUNT, 64'h7FF, 1'b0, 1'b0, 64'h0},
        '{STEP_ITEM,  REG_INVERSE_MODE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1,
          64'hFFFF_FFFF_FFFF_FFFF},
        '{STEP_ITEM,  REG_INVERSE_MODE, 64'd123, 1'b0, 1'b1, 64'd123},
        '{STEP_WRITE, REG_COLUMN_COUNT, 64'd1, 1'b0, 1'b0, 64'h0},
        '{STEP_ITEM,  REG_INVERSE_MODE, 64'd11, 1'b0, 1'b1, 64'd11},
        '{STEP_ITEM,  REG_INVERSE_MODE, 64'd4, 1'b0, 1'b0, 64'h0}
    };

    strided_modular_prefix_sum DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .value_in        (value_in),
        .start_of_tensor (start_of_tensor),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .value_out       (value_out),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Random idle decision, true about 17 times in a hundred outside quiet windows.
    function automatic bit idle_roll(input bit quiet);
        return !quiet && ($urandom_range(99) < 17);
    endfunction

    // Position of the next item after a start marker and any count wrap.
    function automatic void locate_item(input logic sot, output int unsigned col,
                                        output int unsigned row, output int unsigned cols,
                                        output int unsigned rows);
        cols = (cfg_columns == 0) ? 1 : cfg_columns;
        if (cols > MAX_COLUMNS)
            cols = MAX_COLUMNS;
        rows = (cfg_rows == 0) ? 1 : cfg_rows;
        col = sot ? 0 : column_at;
        row = sot ? 0 : row_at;
        if (col >= cols)
            col = 0;
        if (row >= rows)
            row = 0;
    endfunction

    // One conditional subtraction, compared as signed words.
    function automatic word_t reduce_once(input word_t t);
        word_t q;
        q = {1'b0, cfg_modulus};
        return ($signed(t) >= $signed(q)) ? t - q : t;
    endfunction

    // Computes one output coefficient and advances the column state.
    function automatic word_t transform_coefficient(input word_t x, input logic sot);
        int unsigned col, row, cols, rows;
        word_t       prev, y;
        locate_item(sot, col, row, cols, rows);
        prev = column_words[col];
        if (row == 0) begin
            y = x;
            column_words[col] = x;
        end else if (!cfg_inverse) begin
            y = prev + x;
            if (cfg_modular)
                y = reduce_once(y);
            column_words[col] = y;
        end else begin
            if (cfg_modular)
                y = reduce_once(x - prev + {1'b0, cfg_modulus});
            else
                y = x - prev;
            column_words[col] = x;
        end
        column_written[col] = 1'b1;

        // Step to the next column, and to the next row at the end of a row.
        if (col + 1 >= cols) begin
            column_at = 0;
            row_at    = (row + 1 >= rows) ? 0 : row + 1;
        end else begin
            column_at = col + 1;
            row_at    = row;
        end
        return y;
    endfunction

    // Offers one item, with random gaps ahead of it, and records its result.
    task automatic offer_coefficient(input word_t v, input logic sot, input word_t want);
        while (idle_roll(accepted_items >= 200 && accepted_items < 300)) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        value_in        <= v;
        start_of_tensor <= sot;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted_values.push_back(want);
        accepted_items++;
    endtask

    // Stops offering and waits until every predicted result has come out.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (predicted_values.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes one register and mirrors it in the shadow configuration.
    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_INVERSE_MODE: cfg_inverse = data[0];
            REG_MODULAR_MODE: cfg_modular = data[0];
            REG_MODULUS:      cfg_modulus = data[MODULUS_W-1:0];
            REG_COLUMN_COUNT: cfg_columns = data[COLS_CFG_W-1:0];
            REG_ROW_COUNT:    cfg_rows    = data[ROWS_CFG_W-1:0];
            default: ;
        endcase
    endtask

    // Output side: random stalls, a quiet window and one long hold-off.
    initial
    begin : result_sink
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (!hold_done && results_seen >= 320 && in_valid) begin
                hold_left = 60;
                hold_done = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= !idle_roll(results_seen >= 400 && results_seen < 500);
            end
        end
    end

    // Compares every accepted result with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        word_t want;
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (predicted_values.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %h", $time, value_out);
                failures++;
            end else begin
                want = predicted_values.pop_front();
                if (value_out !== want) begin
                    $display("%0t: value_out mismatch: expected %h, actual %h",
                             $time, want, value_out);
                    failures++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     predicted_values.size());
            $display("FAIL strided_modular_prefix_sum");
            $finish;
        end
    end

    // Main stimulus: reset, directed table, then random phases.
    initial
    begin
        int unsigned          random_items, phase, phase_len, col, row, cols, rows;
        word_t                coeff, wide, predicted;
        logic                 sot;
        logic [MODULUS_W-1:0] modulus_pick;

        rst_n           = 1'b0;
        in_valid        = 1'b0;
        value_in        = '0;
        start_of_tensor = 1'b0;
        cfg_write       = 1'b0;
        cfg_index       = REG_INVERSE_MODE;
        cfg_data        = '0;
        cfg_inverse     = 1'b0;
        cfg_modular     = 1'b1;
        cfg_modulus     = 63'd2;
        cfg_columns     = 11'd1;
        cfg_rows        = 16'd1;
        column_at       = 0;
        row_at          = 0;
        accepted_items  = 0;
        results_seen    = 0;
        failures        = 0;
        cycle_count     = 0;
        foreach (column_words[i]) begin
            column_words[i]   = '0;
            column_written[i] = 1'b0;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table.
        foreach (directed_steps[i]) begin
            if (directed_steps[i].kind == STEP_WRITE) begin
                drain_pipeline();
                write_register(directed_steps[i].reg_idx,
                               directed_steps[i].value[CFG_DATA_W-1:0]);
            end else begin
                predicted = transform_coefficient(directed_steps[i].value,
                                                  directed_steps[i].sot);
                offer_coefficient(directed_steps[i].value, directed_steps[i].sot,
                                  directed_steps[i].typed ? directed_steps[i].result
                                                          : predicted);
            end
        end

        // Random phases, each under its own configuration.
        random_items = 0;
        phase        = 0;
        while (random_items < RANDOM_ITEMS) begin
            drain_pipeline();
            write_register(REG_INVERSE_MODE, CFG_DATA_W'($urandom_range(1)));
            write_register(REG_MODULAR_MODE, CFG_DATA_W'($urandom_range(99) < 75));

            wide = {$urandom, $urandom};
            case ($urandom_range(7))
                0: modulus_pick = 63'd2;
                1: modulus_pick = MODULUS_W'($urandom_range(3, 1000));
                2: modulus_pick = 63'h4000_0000_0000_0000;
                3: modulus_pick = 63'h7FFF_FFFF_FFFF_FFFF;
                4, 5: modulus_pick = {1'b0, wide[61:0]} | 63'd2;
                6: modulus_pick = wide[MODULUS_W-1:0];
                default: modulus_pick = MODULUS_W'($urandom_range(1));
            endcase
            write_register(REG_MODULUS, modulus_pick);

            case ($urandom_range(9))
                0: write_register(REG_COLUMN_COUNT, 63'd0);
                1: write_register(REG_COLUMN_COUNT, 63'h7FF);
                2: write_register(REG_COLUMN_COUNT, 63'd1024);
                3: write_register(REG_COLUMN_COUNT, CFG_DATA_W'($urandom_range(9, 40)));
                default: write_register(REG_COLUMN_COUNT, CFG_DATA_W'($urandom_range(1, 8)));
            endcase

            if (phase == 1)
                write_register(REG_ROW_COUNT, 63'hFFFF);
            else
                case ($urandom_range(9))
                    0: write_register(REG_ROW_COUNT, 63'd0);
                    1: write_register(REG_ROW_COUNT, 63'hFFFF);
                    default: write_register(REG_ROW_COUNT, CFG_DATA_W'($urandom_range(1, 6)));
                endcase

            phase_len = $urandom_range(20, 70);
            for (int unsigned k = 0; k < phase_len; k++) begin
                wide = {$urandom, $urandom};
                case ($urandom_range(19))
                    0: coeff = '0;
                    1: coeff = 64'h8000_0000_0000_0000;
                    2: coeff = 64'h7FFF_FFFF_FFFF_FFFF;
                    3: coeff = '1;
                    4: coeff = wide;
                    default: coeff = (cfg_modular && cfg_modulus != 0)
                                     ? wide % {1'b0, cfg_modulus} : wide;
                endcase

                // Mostly whole blocks; a start marker now and then cuts one short.
                sot = (k == 0) ? ($urandom_range(9) < 8) : ($urandom_range(99) < 3);

                // A raised column count must not read a column this block never wrote.
                locate_item(sot, col, row, cols, rows);
                if (row != 0 && !column_written[col])
                    sot = 1'b1;

                predicted = transform_coefficient(coeff, sot);
                offer_coefficient(coeff, sot, predicted);
                random_items++;
            end
            phase++;
        end

        drain_pipeline();
        repeat (6) @(posedge clk);
        if (failures == 0)
            $display("PASS strided_modular_prefix_sum");
        else
            $display("FAIL strided_modular_prefix_sum");
        $finish;
    end

endmodule
